// ----- sv/rtdbp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtdbp_pkg
// Shared types, microcode control word and fixed-point constants for the
// RTD temperature / bridge pressure converter.
// ----------------------------------------------------------------------------
package rtdbp_pkg;

  // Item field widths
  localparam int STATUS_W = 8;
  localparam int CODE_W   = 24;
  localparam int TEMP_W   = 20;
  localparam int PRES_W   = 28;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Converter status codes
  localparam logic [STATUS_W-1:0] ST_BSIG = 8'd1;
  localparam logic [STATUS_W-1:0] ST_BREF = 8'd2;
  localparam logic [STATUS_W-1:0] ST_RTD  = 8'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RTD_FS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_FS = 1'b1;

  localparam logic [CFG_W-1:0] RTD_FS_RESET = 16'd3900;
  localparam logic [CFG_W-1:0] REF_FS_RESET = 16'd3300;

  // Callendar-Van Dusen inverse, reduced to integers (Q16 ohm in, Q8 degC out)
  localparam logic [63:0] ROOT_M     = 64'd65536 * 64'd781660 * 64'd781660;
  localparam logic [31:0] ROOT_SLOPE = 32'd924000000;
  localparam logic [31:0] ROOT_D_MAX = 32'(ROOT_M / 64'd924000000);
  localparam logic [31:0] R0_Q16     = 32'd6553600;
  localparam logic [31:0] ROOT_TOP   = 32'd200104960;
  localparam logic [31:0] C_231      = 32'd231;
  localparam logic [31:0] K_DIV231   = 32'((64'd1 << 36) / 64'd231);

  // Pressure gain 2500/2333 as reciprocal multiply plus one correction
  localparam logic [31:0] C_2500 = 32'd2500;
  localparam logic [31:0] C_2333 = 32'd2333;
  localparam logic [31:0] K_GAIN = 32'((64'd2500 << 31) / 64'd2333);
  localparam logic [31:0] V_SAT  = 32'(((64'd2333 << 28) + 64'd2499) / 64'd2500);

  // Sequencer
  localparam int UPC_W      = 5;
  localparam int CNT_W      = 5;
  localparam int SQRT_STEPS = 28;

  typedef enum logic [2:0] {
    MA_CODE,
    MA_VA,
    MA_VB,
    MA_BR_LO,
    MA_BR_HI
  } mul_a_t;

  typedef enum logic [3:0] {
    MB_RTD_FS,
    MB_REF_FS,
    MB_CODE,
    MB_SLOPE,
    MB_K231,
    MB_C231,
    MB_KGAIN,
    MB_C2500,
    MB_C2333
  } mul_b_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RANGE,
    OP_XLOAD,
    OP_SQRT,
    OP_TDIFF,
    OP_TQ0,
    OP_TFIX,
    OP_BREF,
    OP_ACC,
    OP_VSUM,
    OP_PQ0,
    OP_NSAVE,
    OP_PFIX,
    OP_PSAT
  } dp_op_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_FLAG,
    JC_LOOP
  } jcond_t;

  typedef struct packed {
    logic             mul_en;
    mul_a_t           mul_a;
    mul_b_t           mul_b;
    dp_op_t           op;
    logic             cnt_load;
    jcond_t           jc;
    logic [UPC_W-1:0] target;
    logic             finish;
  } ctrl_t;

  typedef struct packed {
    logic cflag;
    logic out_free;
  } dp_stat_t;

  localparam ctrl_t CTRL_NOP = '{
    mul_en:   1'b0,
    mul_a:    MA_CODE,
    mul_b:    MB_CODE,
    op:       OP_NOP,
    cnt_load: 1'b0,
    jc:       JC_NEXT,
    target:   '0,
    finish:   1'b0
  };

endpackage

// ----- sv/rtdbp_seq.sv -----
// ----------------------------------------------------------------------------
// rtdbp_seq
// Microcode sequencer: dispatches on the status byte, steps through the
// control store and handles jumps and the square-root loop counter.
// ----------------------------------------------------------------------------
module rtdbp_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_accept,
  input  logic [rtdbp_pkg::STATUS_W-1:0]    status_byte,
  input  rtdbp_pkg::dp_stat_t               stat,
  output rtdbp_pkg::ctrl_t                  ctrl,
  output logic                              busy,
  output logic                              out_load
);
  import rtdbp_pkg::*;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } seq_state_t;

  // Program entry points
  localparam logic [UPC_W-1:0] A_RTD   = 5'd0;
  localparam logic [UPC_W-1:0] A_SQRT  = 5'd4;
  localparam logic [UPC_W-1:0] A_BREF  = 5'd10;
  localparam logic [UPC_W-1:0] A_PRES  = 5'd12;
  localparam logic [UPC_W-1:0] A_PSAT  = 5'd19;
  localparam logic [UPC_W-1:0] A_END   = 5'd20;

  seq_state_t       state;
  logic [UPC_W-1:0] pc;
  logic [UPC_W-1:0] pc_next;
  logic [CNT_W-1:0] cnt;
  ctrl_t            word;
  logic             take;

  // Control store
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] a);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (a)
      // RTD: resistance, range check, radicand
      5'd0: begin
        w.mul_en = 1'b1; w.mul_a = MA_CODE; w.mul_b = MB_RTD_FS;
      end
      5'd1: w.op = OP_RANGE;
      5'd2: begin
        w.mul_en = 1'b1; w.mul_a = MA_VA; w.mul_b = MB_SLOPE;
        w.jc = JC_FLAG; w.target = A_END;
      end
      5'd3: begin
        w.op = OP_XLOAD; w.cnt_load = 1'b1;
      end
      // one root bit per pass
      5'd4: begin
        w.op = OP_SQRT; w.jc = JC_LOOP; w.target = A_SQRT;
      end
      5'd5: w.op = OP_TDIFF;
      5'd6: begin
        w.mul_en = 1'b1; w.mul_a = MA_VA; w.mul_b = MB_K231;
      end
      5'd7: w.op = OP_TQ0;
      5'd8: begin
        w.mul_en = 1'b1; w.mul_a = MA_VB; w.mul_b = MB_C231;
      end
      5'd9: begin
        w.op = OP_TFIX; w.jc = JC_ALWAYS; w.target = A_END;
      end
      // bridge reference
      5'd10: begin
        w.mul_en = 1'b1; w.mul_a = MA_CODE; w.mul_b = MB_REF_FS;
      end
      5'd11: begin
        w.op = OP_BREF; w.jc = JC_ALWAYS; w.target = A_END;
      end
      // bridge signal: 32x24 product in two halves, then gain
      5'd12: begin
        w.mul_en = 1'b1; w.mul_a = MA_BR_LO; w.mul_b = MB_CODE;
      end
      5'd13: begin
        w.op = OP_ACC;
        w.mul_en = 1'b1; w.mul_a = MA_BR_HI; w.mul_b = MB_CODE;
      end
      5'd14: w.op = OP_VSUM;
      5'd15: begin
        w.mul_en = 1'b1; w.mul_a = MA_VA; w.mul_b = MB_KGAIN;
        w.jc = JC_FLAG; w.target = A_PSAT;
      end
      5'd16: begin
        w.op = OP_PQ0;
        w.mul_en = 1'b1; w.mul_a = MA_VA; w.mul_b = MB_C2500;
      end
      5'd17: begin
        w.op = OP_NSAVE;
        w.mul_en = 1'b1; w.mul_a = MA_VB; w.mul_b = MB_C2333;
      end
      5'd18: begin
        w.op = OP_PFIX; w.jc = JC_ALWAYS; w.target = A_END;
      end
      5'd19: w.op = OP_PSAT;
      // A_END and unused addresses: hand the result over
      default: w.finish = 1'b1;
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry(input logic [STATUS_W-1:0] s);
    logic [UPC_W-1:0] e;
    unique case (s)
      ST_RTD:  e = A_RTD;
      ST_BREF: e = A_BREF;
      ST_BSIG: e = A_PRES;
      default: e = A_END;
    endcase
    return e;
  endfunction

  // Next address
  always_comb begin
    word = ucode(pc);
    unique case (word.jc)
      JC_NEXT:   take = 1'b0;
      JC_ALWAYS: take = 1'b1;
      JC_FLAG:   take = stat.cflag;
      JC_LOOP:   take = (cnt != '0);
      default:   take = 1'b0;
    endcase
    pc_next = take ? word.target : pc + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      pc    <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        SQ_IDLE: begin
          if (in_accept) begin
            pc    <= entry(status_byte);
            state <= SQ_RUN;
          end
        end
        SQ_RUN: begin
          if (word.finish) begin
            if (stat.out_free) state <= SQ_IDLE;
          end else begin
            pc <= pc_next;
            if (word.cnt_load) begin
              cnt <= CNT_W'(SQRT_STEPS - 1);
            end else if (word.jc == JC_LOOP && cnt != '0) begin
              cnt <= cnt - 5'd1;
            end
          end
        end
        default: state <= SQ_IDLE;
      endcase
    end
  end

  assign ctrl     = (state == SQ_RUN) ? word : CTRL_NOP;
  assign busy     = (state != SQ_IDLE);
  assign out_load = (state == SQ_RUN) && word.finish && stat.out_free;

endmodule

// ----- sv/rtdbp_dp.sv -----
// ----------------------------------------------------------------------------
// rtdbp_dp
// Datapath: config registers, one shared 32x32 multiplier with a registered
// product, work registers, bit-serial square root and the output register.
// ----------------------------------------------------------------------------
module rtdbp_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [rtdbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtdbp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               in_accept,
  input  logic [rtdbp_pkg::CODE_W-1:0]       sample_code,
  input  rtdbp_pkg::ctrl_t                   ctrl,
  input  logic                               out_load,
  output rtdbp_pkg::dp_stat_t                stat,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rtdbp_pkg::TEMP_W-1:0]       temperature,
  output logic [rtdbp_pkg::PRES_W-1:0]       pressure,
  output logic                               temperature_out_of_range
);
  import rtdbp_pkg::*;

  // Config
  logic [CFG_W-1:0]  rtd_full_scale;
  logic [CFG_W-1:0]  reference_full_scale;

  // Held state
  logic [TEMP_W-1:0] held_temperature;
  logic [PRES_W-1:0] held_pressure;
  logic [31:0]       bridge_reference;

  // Work registers
  logic [CODE_W-1:0] code_q;
  logic [63:0]       prod;
  logic [31:0]       va;
  logic [31:0]       vb;
  logic [55:0]       xr;
  logic [29:0]       srem;
  logic [27:0]       root;
  logic              cflag;
  logic              oor;

  // Combinational
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       rq;
  logic [31:0]       range_d;
  logic              range_bad;
  logic [31:0]       sq_base;
  logic [31:0]       sq_trial;
  logic [31:0]       sq_diff;
  logic              sq_ge;
  logic [31:0]       t_rem;
  logic [TEMP_W-1:0] t_val;
  logic [55:0]       vsum;
  logic [39:0]       p_rem;
  logic [PRES_W-1:0] p_val;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rtd_full_scale       <= RTD_FS_RESET;
      reference_full_scale <= REF_FS_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_RTD_FS: rtd_full_scale       <= cfg_data;
        REG_REF_FS: reference_full_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Multiplier operand select
  always_comb begin
    unique case (ctrl.mul_a)
      MA_CODE:  mul_a = {8'd0, code_q};
      MA_VA:    mul_a = va;
      MA_VB:    mul_a = vb;
      MA_BR_LO: mul_a = {16'd0, bridge_reference[15:0]};
      MA_BR_HI: mul_a = {16'd0, bridge_reference[31:16]};
      default:  mul_a = '0;
    endcase
    unique case (ctrl.mul_b)
      MB_RTD_FS: mul_b = {16'd0, rtd_full_scale};
      MB_REF_FS: mul_b = {16'd0, reference_full_scale};
      MB_CODE:   mul_b = {8'd0, code_q};
      MB_SLOPE:  mul_b = ROOT_SLOPE;
      MB_K231:   mul_b = K_DIV231;
      MB_C231:   mul_b = C_231;
      MB_KGAIN:  mul_b = K_GAIN;
      MB_C2500:  mul_b = C_2500;
      MB_C2333:  mul_b = C_2333;
      default:   mul_b = '0;
    endcase
  end

  // Per-op arithmetic
  always_comb begin
    // resistance in Q16 ohm, offset from R0 and domain check
    rq        = prod[39:8];
    range_d   = rq - R0_Q16;
    range_bad = (rq < R0_Q16) || (range_d > ROOT_D_MAX);
    // restoring square root, two radicand bits per pass
    sq_base   = {srem, xr[55:54]};
    sq_trial  = {2'b00, root, 2'b01};
    sq_ge     = (sq_base >= sq_trial);
    sq_diff   = sq_base - sq_trial;
    // divide by 231: estimate is exact or one low
    t_rem     = va - prod[31:0];
    t_val     = vb[TEMP_W-1:0] + TEMP_W'(t_rem >= C_231);
    // bridge voltage from two 16x24 partial products
    vsum      = xr + {prod[39:0], 16'd0};
    // gain divide by 2333: estimate is exact or one low
    p_rem     = xr[39:0] - prod[39:0];
    p_val     = vb[PRES_W-1:0] + PRES_W'(p_rem >= 40'(C_2333));
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) code_q <= sample_code;
    if (ctrl.mul_en) prod <= mul_a * mul_b;

    unique case (ctrl.op)
      OP_RANGE: va <= range_d;
      OP_XLOAD: begin
        xr   <= ROOT_M[55:0] - prod[55:0];
        srem <= '0;
        root <= '0;
      end
      OP_SQRT: begin
        xr   <= {xr[53:0], 2'b00};
        srem <= sq_ge ? sq_diff[29:0] : sq_base[29:0];
        root <= {root[26:0], sq_ge};
      end
      OP_TDIFF: va <= ROOT_TOP - {4'd0, root};
      OP_TQ0:   vb <= {4'd0, prod[63:36]};
      OP_ACC:   xr <= prod[55:0];
      OP_VSUM:  va <= vsum[55:24];
      OP_PQ0:   vb <= prod[62:31];
      OP_NSAVE: xr <= prod[55:0];
      default: ;
    endcase
  end

  // Held state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      held_temperature <= '0;
      held_pressure    <= '0;
      bridge_reference <= '0;
      cflag            <= 1'b0;
      oor              <= 1'b0;
    end else begin
      if (in_accept) oor <= 1'b0;
      unique case (ctrl.op)
        OP_RANGE: begin
          cflag <= range_bad;
          oor   <= range_bad;
        end
        OP_TFIX: held_temperature <= t_val;
        OP_BREF: bridge_reference <= prod[39:8];
        OP_VSUM: cflag            <= (vsum[55:24] >= V_SAT);
        OP_PFIX: held_pressure    <= p_val;
        OP_PSAT: held_pressure    <= '1;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      temperature              <= held_temperature;
      pressure                 <= held_pressure;
      temperature_out_of_range <= oor;
    end
  end

  assign stat.cflag    = cflag;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

// ----- sv/rtd_and_bridge_pressure_conversion_top.sv -----
// ----------------------------------------------------------------------------
// rtd_and_bridge_pressure_conversion_top
// RTD temperature and bridge pressure conversion from converter results.
// ----------------------------------------------------------------------------
// Usage:
//   Input item: status_byte and sample_code, taken when in_valid is high and
//   in_stall is low. Status 3 converts an RTD code to temperature, status 2
//   stores the bridge reference, status 1 converts a bridge code to
//   pressure; other status values change nothing.
//   Every item returns one result item (temperature, pressure,
//   temperature_out_of_range) on out_valid / out_stall.
//   RTD items run a square root that yields one root bit per cycle; it is
//   skipped when the resistance is out of range, and pressure items skip
//   the gain divide when they saturate. One item is in work at a time;
//   in_stall is high while the microcode sequencer runs. A finished result
//   sits in the output register, so the next item is taken while it waits.
//   When the receiver stalls, the sequencer holds on its final step until
//   the output register frees up; the result shown does not change.
//   Reset clears held temperature, pressure and reference and loads the
//   full-scale registers with 3900 and 3300. Config writes (cfg_write_enable,
//   cfg_index, cfg_data) take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module rtd_and_bridge_pressure_conversion_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [rtdbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtdbp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rtdbp_pkg::STATUS_W-1:0]     status_byte,
  input  logic [rtdbp_pkg::CODE_W-1:0]       sample_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rtdbp_pkg::TEMP_W-1:0]       temperature,
  output logic [rtdbp_pkg::PRES_W-1:0]       pressure,
  output logic                               temperature_out_of_range
);
  import rtdbp_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;
  logic     busy;
  logic     out_load;
  logic     in_accept;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  rtdbp_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_accept   (in_accept),
    .status_byte (status_byte),
    .stat        (stat),
    .ctrl        (ctrl),
    .busy        (busy),
    .out_load    (out_load)
  );

  rtdbp_dp u_dp (
    .clk                      (clk),
    .rst                      (rst),
    .cfg_write_enable         (cfg_write_enable),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_accept                (in_accept),
    .sample_code              (sample_code),
    .ctrl                     (ctrl),
    .out_load                 (out_load),
    .stat                     (stat),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .temperature              (temperature),
    .pressure                 (pressure),
    .temperature_out_of_range (temperature_out_of_range)
  );

endmodule

// ----- tb/sv/conversion_checker.sv -----
// ----------------------------------------------------------------------------
// conversion_checker
// Watches the register port and both item channels of the RTD / bridge
// converter. Every accepted input item is run through a local fixed-point
// model of the conversion, and each accepted result item is compared field
// by field with the oldest predicted reading.
// ----------------------------------------------------------------------------
module conversion_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_enable,
  input  logic [rtdbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtdbp_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [rtdbp_pkg::STATUS_W-1:0]    status_byte,
  input  logic [rtdbp_pkg::CODE_W-1:0]      sample_code,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [rtdbp_pkg::TEMP_W-1:0]      temperature,
  input  logic [rtdbp_pkg::PRES_W-1:0]      pressure,
  input  logic                              temperature_out_of_range,
  output int                                mismatch_count,
  output int                                pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtdbp_pkg::*;

  // Inverse CVD in integers: R0 in Q16 ohm, slope and radicand scaled so that
  // T(Q8) = (ROOT_TOP - sqrt(M - (R - R0) * SLOPE)) / 231
  localparam logic [63:0] R0_OHMS    = 64'd6553600;
  localparam logic [63:0] CVD_SLOPE  = 64'd924000000;
  localparam logic [63:0] CVD_M      = 64'd65536 * 64'd781660 * 64'd781660;
  localparam logic [63:0] CVD_TOP    = 64'd200104960;
  localparam logic [63:0] CVD_DIV    = 64'd231;
  localparam logic [63:0] GAIN_UP    = 64'd2500;
  localparam logic [63:0] GAIN_DOWN  = 64'd2333;
  localparam logic [63:0] PRES_LIMIT = 64'h0FFF_FFFF;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [PRES_W-1:0] pressure;
    logic              out_of_range;
  } reading_t;

  reading_t          expected_readings[$];
  int                mismatches = 0;

  // Model state
  logic [CFG_W-1:0]  rtd_fs;
  logic [CFG_W-1:0]  ref_fs;
  logic [TEMP_W-1:0] held_temp;
  logic [PRES_W-1:0] held_pres;
  logic [31:0]       bridge_ref;

  assign mismatch_count = mismatches;

  // Largest r with r*r <= x, one bit at a time
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Apply one input item to the model state and return the reading it gives
  function automatic reading_t convert_item(input logic [STATUS_W-1:0] st,
                                            input logic [CODE_W-1:0] code);
    logic [63:0] ohms;
    logic [63:0] excess;
    logic [63:0] degrees;
    logic [63:0] volts;
    logic [63:0] bar;
    reading_t    r;
    r.out_of_range = 1'b0;
    if (st == ST_RTD) begin
      ohms = (64'(code) * 64'(rtd_fs)) >> 8;
      if (ohms < R0_OHMS) begin
        r.out_of_range = 1'b1;
      end else begin
        excess = (ohms - R0_OHMS) * CVD_SLOPE;
        if (excess > CVD_M) begin
          r.out_of_range = 1'b1;
        end else begin
          degrees   = (CVD_TOP - floor_sqrt(CVD_M - excess)) / CVD_DIV;
          held_temp = degrees[TEMP_W-1:0];
        end
      end
    end else if (st == ST_BREF) begin
      ohms       = (64'(code) * 64'(ref_fs)) >> 8;
      bridge_ref = ohms[31:0];
    end else if (st == ST_BSIG) begin
      volts = (64'(bridge_ref) * 64'(code)) >> 24;
      bar   = volts * GAIN_UP / GAIN_DOWN;
      if (bar > PRES_LIMIT) bar = PRES_LIMIT;
      held_pres = bar[PRES_W-1:0];
    end
    r.temperature = held_temp;
    r.pressure    = held_pres;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Track registers, predict on input accept, check on output accept
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      rtd_fs     = RTD_FS_RESET;
      ref_fs     = REF_FS_RESET;
      held_temp  = '0;
      held_pres  = '0;
      bridge_ref = '0;
      expected_readings.delete();
    end else begin
      if (cfg_write_enable) begin
        if (cfg_index == REG_RTD_FS) rtd_fs = cfg_data;
        else if (cfg_index == REG_REF_FS) ref_fs = cfg_data;
      end
      // results first: an item taken this edge cannot leave on the same edge
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected result T=%0d P=%0d flag=%0b",
                                    temperature, pressure,
                                    temperature_out_of_range));
        end else begin
          want = expected_readings.pop_front();
          if (temperature !== want.temperature)
            report_mismatch($sformatf("temperature %0d, expected %0d",
                                      temperature, want.temperature));
          if (pressure !== want.pressure)
            report_mismatch($sformatf("pressure %0d, expected %0d",
                                      pressure, want.pressure));
          if (temperature_out_of_range !== want.out_of_range)
            report_mismatch($sformatf("out of range flag %0b, expected %0b",
                                      temperature_out_of_range,
                                      want.out_of_range));
        end
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(convert_item(status_byte, sample_code));
    end
    pending_results = expected_readings.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RTD temperature / bridge pressure converter.
// Runs directed corner items, then random item streams over several
// full-scale settings and idle / stall patterns; conversion_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtdbp_pkg::*;

  localparam int          CYCLE_LIMIT = 500000;
  localparam logic [63:0] R0_OHMS     = 64'd6553600;
  // top of the square root's domain, Q16 ohm
  localparam logic [63:0] RMAX_OHMS   =
    R0_OHMS + (64'd65536 * 64'd781660 * 64'd781660) / 64'd924000000;
  localparam logic [63:0] CODE_MAX    = 64'hFF_FFFF;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_enable;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [STATUS_W-1:0]  status_byte;
  logic [CODE_W-1:0]    sample_code;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TEMP_W-1:0]    temperature;
  logic [PRES_W-1:0]    pressure;
  logic                 temperature_out_of_range;

  int                   mismatch_count;
  int                   pending_results;
  int                   cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  logic [CFG_W-1:0]     cur_rtd_fs;

  rtd_and_bridge_pressure_conversion_top u_top (
    .clk                      (clk),
    .rst                      (rst),
    .cfg_write_enable         (cfg_write_enable),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .status_byte              (status_byte),
    .sample_code              (sample_code),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .temperature              (temperature),
    .pressure                 (pressure),
    .temperature_out_of_range (temperature_out_of_range)
  );

  conversion_checker u_checker (
    .clk                      (clk),
    .rst                      (rst),
    .cfg_write_enable         (cfg_write_enable),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .status_byte              (status_byte),
    .sample_code              (sample_code),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .temperature              (temperature),
    .pressure                 (pressure),
    .temperature_out_of_range (temperature_out_of_range),
    .mismatch_count           (mismatch_count),
    .pending_results          (pending_results)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall = !rst && ($urandom_range(99) < stall_pct);
  end

  // Present one item, with random idle cycles ahead of it, and wait for accept
  task automatic send_item(input logic [STATUS_W-1:0] st, input logic [CODE_W-1:0] code);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    status_byte = st;
    sample_code = code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Code range that maps to a resistance inside the root's domain
  task automatic rtd_window(output logic [63:0] lo, output logic [63:0] hi);
    if (cur_rtd_fs == '0) begin
      lo = CODE_MAX + 1;
      hi = '0;
    end else begin
      lo = (R0_OHMS * 256 + cur_rtd_fs - 1) / cur_rtd_fs;
      hi = ((RMAX_OHMS + 1) * 256 - 1) / cur_rtd_fs;
      if (hi > CODE_MAX) hi = CODE_MAX;
    end
  endtask

  // Mostly well-formed conversions; some noise status values
  task automatic send_random_item();
    logic [63:0]         lo;
    logic [63:0]         hi;
    logic [CODE_W-1:0]   code;
    logic [STATUS_W-1:0] st;
    int                  pick;
    int                  shape;
    pick  = $urandom_range(99);
    shape = $urandom_range(99);
    code  = CODE_W'($urandom());
    if (pick < 40) begin
      st = ST_RTD;
      rtd_window(lo, hi);
      if (lo <= hi) begin
        if (shape < 65) code = CODE_W'($urandom_range(32'(lo), 32'(hi)));
        else if (shape < 75) code = CODE_W'(lo + 64'($urandom_range(2)) - 64'd1);
        else if (shape < 85) code = CODE_W'(hi + 64'($urandom_range(2)) - 64'd1);
      end
    end else if (pick < 58) begin
      st = ST_BREF;
    end else if (pick < 88) begin
      st = ST_BSIG;
    end else begin
      st = STATUS_W'($urandom());
    end
    send_item(st, code);
  endtask

  // Idle until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write_enable = 1'b1;
    cfg_index        = idx;
    cfg_data         = value;
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] rtd_fs, input logic [CFG_W-1:0] ref_fs);
    write_register(REG_RTD_FS, rtd_fs);
    write_register(REG_REF_FS, ref_fs);
    cur_rtd_fs = rtd_fs;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index        = REG_RTD_FS;
    cfg_data         = '0;
    in_valid         = 1'b0;
    status_byte      = '0;
    sample_code      = '0;
    cur_rtd_fs       = RTD_FS_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: corners of every status, no idling
    set_idling(0, 0);
    rtd_window(lo, hi);
    send_item(8'd0, 24'd0);
    send_item(8'hFF, 24'hFF_FFFF);
    send_item(ST_BSIG, 24'hFF_FFFF);        // reference still zero
    send_item(ST_RTD, 24'd0);               // below R0
    send_item(ST_RTD, CODE_W'(lo - 64'd1));
    send_item(ST_RTD, CODE_W'(lo));         // lowest code at or above R0
    send_item(ST_RTD, CODE_W'((lo + hi) / 64'd2));
    send_item(ST_RTD, CODE_W'(hi));         // edge of the root's domain
    send_item(ST_RTD, CODE_W'(hi + 64'd1)); // just past it
    send_item(ST_RTD, 24'hFF_FFFF);
    send_item(ST_BREF, 24'hFF_FFFF);
    send_item(ST_BSIG, 24'hFF_FFFF);
    send_item(ST_BSIG, 24'd0);
    send_item(ST_BREF, 24'd0);
    send_item(ST_BSIG, 24'h80_0000);
    send_item(8'd4, 24'h12_3456);
    send_item(ST_BREF, 24'h80_0000);
    send_item(ST_BSIG, 24'h7F_FFFF);
    repeat (70) send_random_item();
    wait_for_results();

    // Largest full scales: pressure saturates
    configure(16'hFFFF, 16'hFFFF);
    set_idling(88, 0);
    rtd_window(lo, hi);
    send_item(ST_BREF, 24'hFF_FFFF);
    send_item(ST_BSIG, 24'hFF_FFFF);
    send_item(ST_RTD, CODE_W'(lo));
    send_item(ST_RTD, CODE_W'(hi));
    repeat (75) send_random_item();
    wait_for_results();

    // Smallest nonzero full scales: RTD always below R0
    configure(16'd1, 16'd1);
    set_idling(0, 88);
    repeat (60) send_random_item();
    wait_for_results();

    // Zero full scales
    configure(16'd0, 16'd0);
    set_idling(13, 13);
    send_item(ST_RTD, 24'hFF_FFFF);
    send_item(ST_BREF, 24'hFF_FFFF);
    send_item(ST_BSIG, 24'hFF_FFFF);
    repeat (20) send_random_item();
    wait_for_results();

    configure(CFG_W'($urandom_range(2000, 8000)), CFG_W'($urandom_range(1, 65535)));
    set_idling(13, 13);
    repeat (75) send_random_item();
    wait_for_results();

    configure(RTD_FS_RESET, REF_FS_RESET);
    set_idling(0, 88);
    repeat (75) send_random_item();
    wait_for_results();

    configure(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(1, 65535)));
    set_idling(88, 0);
    repeat (75) send_random_item();
    wait_for_results();

    // Let any stray result show up before the verdict
    set_idling(0, 0);
    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
